>>> sv/fpfa_pkg.sv
// ============================================================================
// fpfa_pkg - shared definitions for the fixed partition fit allocator
// Operation and policy codes, register indexes and the result record.
// ============================================================================
package fpfa_pkg;

    localparam int SLOT_W     = 4;
    localparam int AMOUNT_W   = 16;
    localparam int HOLE_ID_W  = 4;
    localparam int LEFTOVER_W = 16;
    localparam int POLICY_W   = 2;
    localparam int COUNT_W    = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_ALLOC = 1'b1;

    // fit policies; the spare code behaves as first fit
    localparam logic [POLICY_W-1:0] POLICY_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] POLICY_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] POLICY_WORST = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POLICY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLES  = 2'd1;

    typedef struct packed {
        logic                  granted;
        logic [HOLE_ID_W-1:0]  chosen_hole;
        logic [LEFTOVER_W-1:0] leftover;
    } result_t;

endpackage

>>> sv/fpfa_ram.sv
// ============================================================================
// fpfa_ram - generic single write, single read RAM
// One write port and one read port, read data registered.
// ============================================================================
module fpfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/fpfa_queue.sv
// ============================================================================
// fpfa_queue - short command queue between front and back
// Register based FIFO; push and pop may happen in the same cycle.
// ============================================================================
module fpfa_queue #(
    parameter int WIDTH = 21,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head,
    output logic             empty,
    output logic             full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CW'(DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> sv/fpfa_front.sv
// ============================================================================
// fpfa_front - command intake and classification
// Trim the amount, range check the slot, drop stray loads, pack the entry.
// ============================================================================
module fpfa_front #(
    parameter int HOLES     = 16,
    parameter int SIZE_BITS = 16
) (
    input  logic                                   start,
    input  logic                                   full,
    input  logic                                   operation,
    input  logic [fpfa_pkg::SLOT_W-1:0]            slot,
    input  logic [fpfa_pkg::AMOUNT_W-1:0]          amount,
    output logic                                   push,
    output logic [1+((HOLES > 1) ? $clog2(HOLES) : 1)+SIZE_BITS-1:0] entry
);

    localparam int AW = (HOLES > 1) ? $clog2(HOLES) : 1;

    logic                 slot_ok;
    logic [AW-1:0]        addr;
    logic [SIZE_BITS-1:0] amt;

    assign slot_ok = (32'(slot) < HOLES);
    assign addr    = AW'(slot);
    assign amt     = SIZE_BITS'(amount);

    // drop a load aimed beyond the table; it has no effect and no result
    assign push  = start && !full && ((operation == fpfa_pkg::OP_ALLOC) || slot_ok);
    assign entry = {operation, addr, amt};

endmodule

>>> sv/fpfa_back.sv
// ============================================================================
// fpfa_back - command execution
// Write loads into the hole table, scan it for allocations, write back.
// ============================================================================
module fpfa_back #(
    parameter int HOLES     = 16,
    parameter int SIZE_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   q_empty,
    input  logic [1+((HOLES > 1) ? $clog2(HOLES) : 1)+SIZE_BITS-1:0] q_head,
    output logic                                   q_pop,
    input  logic [fpfa_pkg::POLICY_W-1:0]          policy,
    input  logic [fpfa_pkg::COUNT_W-1:0]           holes_in_use,
    output logic                                   wr_en,
    output logic [((HOLES > 1) ? $clog2(HOLES) : 1)-1:0] wr_addr,
    output logic [SIZE_BITS-1:0]                   wr_data,
    output logic [((HOLES > 1) ? $clog2(HOLES) : 1)-1:0] rd_addr,
    input  logic [SIZE_BITS-1:0]                   rd_data,
    output logic                                   done,
    output fpfa_pkg::result_t                      result
);

    localparam int AW = (HOLES > 1) ? $clog2(HOLES) : 1;
    localparam int CW = $clog2(HOLES + 1);
    localparam int EW = 1 + AW + SIZE_BITS;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [SIZE_BITS-1:0] amt_reg, amt_next;
    logic [CW-1:0]        scan_reg, scan_next;
    logic [CW-1:0]        rd_idx_reg, rd_idx_next;
    logic                 pipe_vld_reg, pipe_vld_next;
    logic [AW-1:0]        pipe_idx_reg, pipe_idx_next;
    logic                 vld_rd_reg, vld_rd_next;
    logic                 found_reg, found_next;
    logic [AW-1:0]        pick_reg, pick_next;
    logic [SIZE_BITS-1:0] rest_reg, rest_next;
    logic [HOLES-1:0]     valid_reg;
    logic                 done_reg, done_next;
    fpfa_pkg::result_t    result_reg, result_next;

    logic                 head_op;
    logic [AW-1:0]        head_addr;
    logic [SIZE_BITS-1:0] head_amt;
    logic [CW-1:0]        scan_lim;
    logic [SIZE_BITS-1:0] hole_size;
    logic [SIZE_BITS-1:0] rest;
    logic                 fits, best, worst, first, take, issue, finish;

    assign head_op   = q_head[EW-1];
    assign head_addr = q_head[EW-2 -: AW];
    assign head_amt  = q_head[SIZE_BITS-1:0];

    // clamp the scan length to the table depth
    assign scan_lim = (32'(holes_in_use) > HOLES) ? CW'(HOLES) : CW'(holes_in_use);

    // an entry never written since reset reads as an empty hole
    assign hole_size = vld_rd_reg ? rd_data : '0;
    assign fits      = (hole_size >= amt_reg);
    assign rest      = hole_size - amt_reg;
    assign best      = (policy == fpfa_pkg::POLICY_BEST);
    assign worst     = (policy == fpfa_pkg::POLICY_WORST);
    assign first     = !best && !worst;
    assign take      = pipe_vld_reg && fits &&
                       (!found_reg || (best && (rest < rest_reg)) ||
                        (worst && (rest > rest_reg)));

    assign rd_addr = rd_idx_reg[AW-1:0];
    assign issue   = (state_reg == ST_SCAN) && (rd_idx_reg < scan_reg);
    assign finish  = (!pipe_vld_reg && !issue) || (first && found_reg);

    always_comb
    begin
        state_next    = state_reg;
        amt_next      = amt_reg;
        scan_next     = scan_reg;
        rd_idx_next   = rd_idx_reg;
        pipe_vld_next = 1'b0;
        pipe_idx_next = pipe_idx_reg;
        vld_rd_next   = 1'b0;
        found_next    = found_reg;
        pick_next     = pick_reg;
        rest_next     = rest_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        q_pop         = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = head_addr;
        wr_data       = head_amt;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    if (head_op == fpfa_pkg::OP_LOAD)
                    begin
                        wr_en = 1'b1;
                    end
                    else
                    begin
                        amt_next    = head_amt;
                        scan_next   = scan_lim;
                        rd_idx_next = '0;
                        found_next  = 1'b0;
                        pick_next   = '0;
                        rest_next   = '0;
                        if (scan_lim == '0)
                        begin
                            done_next   = 1'b1;
                            result_next = '0;
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                // issue the next read while judging the hole read last cycle
                if (issue)
                begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                    vld_rd_next = valid_reg[rd_addr];
                end
                pipe_vld_next = issue;
                pipe_idx_next = rd_addr;
                if (take)
                begin
                    found_next = 1'b1;
                    pick_next  = pipe_idx_reg;
                    rest_next  = rest;
                end
                if (finish)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                done_next = 1'b1;
                if (found_reg)
                begin
                    wr_en                   = 1'b1;
                    wr_addr                 = pick_reg;
                    wr_data                 = rest_reg;
                    result_next.granted     = 1'b1;
                    result_next.chosen_hole = fpfa_pkg::HOLE_ID_W'(pick_reg);
                    result_next.leftover    = fpfa_pkg::LEFTOVER_W'(rest_reg);
                end
                else
                begin
                    result_next = '0;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            pipe_vld_reg <= 1'b0;
            found_reg    <= 1'b0;
            valid_reg    <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pipe_vld_reg <= pipe_vld_next;
            found_reg    <= found_next;
            done_reg     <= done_next;
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        amt_reg      <= amt_next;
        scan_reg     <= scan_next;
        rd_idx_reg   <= rd_idx_next;
        pipe_idx_reg <= pipe_idx_next;
        vld_rd_reg   <= vld_rd_next;
        pick_reg     <= pick_next;
        rest_reg     <= rest_next;
        result_reg   <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> sv/fixed_partition_fit_allocator.sv
// ============================================================================
// fixed_partition_fit_allocator - first, best and worst fit hole allocator
// Hole table with a command queue between intake and a sequential scanner.
// ============================================================================
// Usage:
//   Command channel: a transaction is taken on a rising edge with start high
//   and busy low. operation selects a hole load (slot, amount) or an
//   allocation of amount bytes. busy rises only when the two-entry command
//   queue is full, so commands may be issued while the scanner works.
//   Result channel: one result per allocation, shown for a single cycle with
//   done high; loads produce none. The receiver cannot stall, so results are
//   never held back and never lost.
//   Configuration: cfg_valid/cfg_ready write policy (index 0) or
//   holes_in_use (index 1); cfg_ready is always high. Write only when idle.
// Timing:
//   A load is written into the table as it leaves the queue. An allocation
//   scans holes_in_use entries clamped to HOLES, then writes back any pick
//   and raises done; first fit stops after the first hit. With nothing to
//   scan, done rises in the cycle straight after the allocation leaves the
//   queue. The hole table RAM yields one entry per cycle to the compare and
//   subtract unit.
// Reset:
//   Empty the queue, return to idle, clear the control and configuration
//   registers and mark every hole invalid so it reads as size zero. No clearing pass is needed.
// ============================================================================
module fixed_partition_fit_allocator #(
    parameter int HOLES     = 16,
    parameter int SIZE_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  operation,
    input  logic [fpfa_pkg::SLOT_W-1:0]           slot,
    input  logic [fpfa_pkg::AMOUNT_W-1:0]         amount,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [fpfa_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [fpfa_pkg::CFG_DATA_W-1:0]       cfg_data,
    output logic                                  done,
    output logic                                  granted,
    output logic [fpfa_pkg::HOLE_ID_W-1:0]        chosen_hole,
    output logic [fpfa_pkg::LEFTOVER_W-1:0]       leftover
);

    localparam int AW = (HOLES > 1) ? $clog2(HOLES) : 1;
    localparam int EW = 1 + AW + SIZE_BITS;

    // configuration registers
    logic [fpfa_pkg::POLICY_W-1:0] policy_reg;
    logic [fpfa_pkg::COUNT_W-1:0]  holes_reg;

    // queue and table wiring
    logic                 push, pop, q_empty, q_full;
    logic [EW-1:0]        entry, head;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr, rd_addr;
    logic [SIZE_BITS-1:0] wr_data, rd_data;
    fpfa_pkg::result_t    result;

    assign cfg_ready = 1'b1;

    // take configuration writes at any time; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= fpfa_pkg::POLICY_FIRST;
            holes_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                fpfa_pkg::REG_POLICY: policy_reg <= cfg_data[fpfa_pkg::POLICY_W-1:0];
                fpfa_pkg::REG_HOLES:  holes_reg  <= cfg_data[fpfa_pkg::COUNT_W-1:0];
                default:              ;
            endcase
        end
    end

    // intake: classify and trim each command before queueing
    fpfa_front #(
        .HOLES     (HOLES),
        .SIZE_BITS (SIZE_BITS)
    ) u_front (
        .start     (start),
        .full      (q_full),
        .operation (operation),
        .slot      (slot),
        .amount    (amount),
        .push      (push),
        .entry     (entry)
    );

    // hold commands while the scanner is occupied
    fpfa_queue #(
        .WIDTH (EW),
        .DEPTH (2)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (entry),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty),
        .full      (q_full)
    );

    assign busy = q_full;

    // execution: loads, fit scan and write-back
    fpfa_back #(
        .HOLES     (HOLES),
        .SIZE_BITS (SIZE_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_head       (head),
        .q_pop        (pop),
        .policy       (policy_reg),
        .holes_in_use (holes_reg),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .done         (done),
        .result       (result)
    );

    // hole size table
    fpfa_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (HOLES)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign granted     = result.granted;
    assign chosen_hole = result.chosen_hole;
    assign leftover    = result.leftover;

endmodule
